[sv/frame_hex_console_ring_top_defines.svh]
// ----------------------------------------------------------------------------
// frame_hex_console_ring_top_defines.svh
// assertion macros used by the console ring top
// ----------------------------------------------------------------------------
`ifndef FRAME_HEX_CONSOLE_RING_TOP_DEFINES_SVH
`define FRAME_HEX_CONSOLE_RING_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define FHCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define FHCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/fhcr_pkg.sv]
// ----------------------------------------------------------------------------
// fhcr_pkg
// types, constants and character helpers for the hex console ring
// ----------------------------------------------------------------------------
`default_nettype none

package fhcr_pkg;

   // ring geometry
   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int POS_W      = 32;
   localparam int REM_W      = 10;

   // transaction kinds
   localparam logic [1:0] KIND_CAPTURE = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;

   // framing bytes
   localparam logic [7:0] BYTE_ARROW  = 8'h01;
   localparam logic [7:0] BYTE_ESCAPE = 8'h02;
   localparam logic [7:0] BYTE_EOL    = 8'h03;
   localparam logic [7:0] ESC_MASK    = 8'h10;

   // output characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ALPHA = 8'h37;

   typedef enum logic [1:0] {
      CLS_ARROW,
      CLS_NEWLINE,
      CLS_HEX
   } char_class_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data_byte;
      logic             direction;
      logic [POS_W-1:0] start_pos;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]       text_char;
      logic [POS_W-1:0] abs_position;
      logic [REM_W-1:0] remaining;
      logic             is_empty;
   } rsp_payload_type;

   // commands from the sequencer to the ring
   typedef struct packed {
      logic             put;
      logic [7:0]       put_char;
      logic             clear;
      logic             rd_en;
      logic [PTR_W-1:0] rd_off;
   } ring_cmd_type;

   // ring status seen by the sequencer
   typedef struct packed {
      logic [POS_W-1:0] dropped;
      logic [PTR_W-1:0] held;
   } ring_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = CH_ZERO + {4'd0, nib};
      end else begin
         res = CH_ALPHA + {4'd0, nib};
      end
      return res;
   endfunction

   // character number idx of the text for one captured byte
   function automatic logic [7:0] char_at(input char_class_type cls,
                                          input logic [7:0] v,
                                          input logic dir,
                                          input logic [1:0] idx);
      logic [7:0] res;
      res = CH_SPACE;
      unique case (cls)
         CLS_ARROW: begin
            unique case (idx)
               2'd0:    res = CH_SPACE;
               2'd1:    res = dir ? CH_DASH : CH_LT;
               2'd2:    res = dir ? CH_GT : CH_DASH;
               default: res = CH_SPACE;
            endcase
         end
         CLS_NEWLINE: begin
            res = CH_NL;
         end
         CLS_HEX: begin
            unique case (idx)
               2'd0:    res = hex_digit(v[7:4]);
               2'd1:    res = hex_digit(v[3:0]);
               default: res = CH_SPACE;
            endcase
         end
         default: res = CH_SPACE;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

[sv/frame_hex_console_ring_top.sv]
// ----------------------------------------------------------------------------
// frame_hex_console_ring_top
// serial capture console: bytes become text in an overwriting ring
// ----------------------------------------------------------------------------
// usage
//   req channel carries one transaction: capture a byte, read one character
//   at an absolute position, or clear the ring. rsp channel returns one
//   transaction for each read only; capture and clear return nothing.
//   a capture writes one character per cycle through the single store port:
//   arrow 4 characters, newline 1, hex 3, escape byte 0 (taken in the idle cycle).
//   req_stall is high while characters are written, so a capture occupies
//   the block until its last character is written. a clear never raises req_stall.
//   a read walks the shared 32-bit subtract/compare, clamp, store read and
//   output load steps; rsp_valid is set by the output load when the output is free.
//   rsp is registered; a new request is taken while a result waits, and a
//   read waits in its last step while rsp_stall holds the previous result.
//   reset empties the ring, zeroes the drop counter and the escape flag;
//   store contents are not cleared and only written entries are ever returned.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_hex_console_ring_top_defines.svh"

module frame_hex_console_ring_top
   import fhcr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT,
      ST_RD_DIFF,
      ST_RD_CLAMP,
      ST_RD_MEM,
      ST_RD_OUT
   } state_type;

   state_type        state_ff;
   logic             esc_ff;
   char_class_type   cls_ff;
   logic [7:0]       byte_ff;
   logic             dir_ff;
   logic [1:0]       idx_ff;
   logic [1:0]       last_idx_ff;
   logic [POS_W-1:0] start_ff;
   logic [POS_W-1:0] diff_ff;
   logic             below_ff;
   logic [PTR_W-1:0] off_ff;
   logic [POS_W-1:0] abs_ff;
   logic [REM_W-1:0] rem_ff;
   logic             empty_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_payload_type  rsp_ff;

   ring_cmd_type     cmd;
   ring_status_type  status;
   logic [7:0]       rd_data;

   logic             req_accept;
   logic             out_free;
   logic [POS_W:0]   diff_wide;
   logic [PTR_W-1:0] off_in;
   logic [7:0]       byte_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // escape applied to a hex byte as it is taken
   assign byte_in = esc_ff ? (req_payload.data_byte ^ ESC_MASK) : req_payload.data_byte;

   // shared subtract gives offset and the below-oldest borrow
   assign diff_wide = {1'b0, start_ff} - {1'b0, status.dropped};

   // clamp offset into the held range
   always_comb begin
      if (below_ff) begin
         off_in = '0;
      end else if (diff_ff > POS_W'(status.held)) begin
         off_in = status.held;
      end else begin
         off_in = diff_ff[PTR_W-1:0];
      end
   end

   // result valid holds until taken, set when a read finishes
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if ((state_ff == ST_RD_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // ring commands
   always_comb begin
      cmd.put      = (state_ff == ST_PUT);
      cmd.put_char = char_at(cls_ff, byte_ff, dir_ff, idx_ff);
      cmd.clear    = req_accept && (req_payload.kind == KIND_CLEAR);
      cmd.rd_en    = (state_ff == ST_RD_MEM);
      cmd.rd_off   = off_ff;
   end

   fhcr_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .rd_data (rd_data)
   );

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  priority if (req_payload.kind == KIND_CAPTURE) begin
                     dir_ff <= req_payload.direction;
                     idx_ff <= 2'd0;
                     priority if (req_payload.data_byte == BYTE_ESCAPE) begin
                        esc_ff <= 1'b1;
                     end else if (req_payload.data_byte == BYTE_ARROW) begin
                        cls_ff      <= CLS_ARROW;
                        last_idx_ff <= 2'd3;
                        state_ff    <= ST_PUT;
                     end else if (req_payload.data_byte == BYTE_EOL) begin
                        cls_ff      <= CLS_NEWLINE;
                        last_idx_ff <= 2'd0;
                        state_ff    <= ST_PUT;
                     end else begin
                        cls_ff      <= CLS_HEX;
                        byte_ff     <= byte_in;
                        esc_ff      <= 1'b0;
                        last_idx_ff <= 2'd2;
                        state_ff    <= ST_PUT;
                     end
                  end else if (req_payload.kind == KIND_READ) begin
                     start_ff <= req_payload.start_pos;
                     state_ff <= ST_RD_DIFF;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_PUT: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == last_idx_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RD_DIFF: begin
               diff_ff  <= diff_wide[POS_W-1:0];
               below_ff <= diff_wide[POS_W];
               state_ff <= ST_RD_CLAMP;
            end
            ST_RD_CLAMP: begin
               off_ff   <= off_in;
               state_ff <= ST_RD_MEM;
            end
            ST_RD_MEM: begin
               abs_ff   <= status.dropped + POS_W'(off_ff);
               rem_ff   <= REM_W'(status.held - off_ff);
               empty_ff <= (off_ff == status.held);
               state_ff <= ST_RD_OUT;
            end
            ST_RD_OUT: begin
               if (out_free) begin
                  rsp_ff.text_char    <= empty_ff ? 8'd0 : rd_data;
                  rsp_ff.abs_position <= abs_ff;
                  rsp_ff.remaining    <= rem_ff;
                  rsp_ff.is_empty     <= empty_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `FHCR_ASSERT_NEXT(a_read_enters_walk, clock, reset, req_accept && (req_payload.kind == KIND_READ), state_ff == ST_RD_DIFF, "read transaction did not start the read walk")
   `FHCR_ASSERT_NOW(a_offset_clamped, clock, reset, state_ff == ST_RD_MEM, off_ff <= status.held, "read offset beyond held characters")
   `FHCR_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == ST_RD_OUT) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "finished read did not produce a result")

endmodule

`default_nettype wire

[sv/fhcr_ring.sv]
// ----------------------------------------------------------------------------
// fhcr_ring
// overwriting ring store with write/read pointers and drop counter
// ----------------------------------------------------------------------------
`default_nettype none

module fhcr_ring
   import fhcr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ring_cmd_type    cmd,
   output ring_status_type      status,
   output logic [7:0]           rd_data
);

   logic [7:0]       store_mem [RING_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [POS_W-1:0] dropped_ff;
   logic [7:0]       rd_data_ff;

   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   held_wrap;
   logic [PTR_W-1:0] held;
   logic [PTR_W:0]   addr_sum;
   logic [PTR_W-1:0] rd_addr;

   // pointer advance with wrap at the ring depth
   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   // characters held between read and write pointer
   assign held_wrap = {1'b0, wr_ptr_ff} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rd_ptr_ff};
   assign held      = (wr_ptr_ff >= rd_ptr_ff) ? wr_ptr_ff - rd_ptr_ff
                                               : held_wrap[PTR_W-1:0];

   // read address is read pointer plus offset, folded once
   assign addr_sum = {1'b0, rd_ptr_ff} + {1'b0, cmd.rd_off};
   assign rd_addr  = (addr_sum >= (PTR_W+1)'(RING_DEPTH))
                     ? PTR_W'(addr_sum - (PTR_W+1)'(RING_DEPTH))
                     : addr_sum[PTR_W-1:0];

   // pointers and drop counter
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         dropped_ff <= '0;
      end else if (cmd.put) begin
         wr_ptr_ff <= wr_ptr_in;
         if (wr_ptr_in == rd_ptr_ff) begin
            rd_ptr_ff  <= rd_ptr_in;
            dropped_ff <= dropped_ff + 1'b1;
         end
      end
   end

   // single-port store
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         store_mem[wr_ptr_ff] <= cmd.put_char;
      end else if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign status.dropped = dropped_ff;
   assign status.held    = held;
   assign rd_data        = rd_data_ff;

endmodule

`default_nettype wire
